>>> src/tewf_pkg.sv
`default_nettype none

package tewf_pkg;

  // Operation carried in tuser
  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_CLOSE = 2'd1,
    OP_SET   = 2'd2,
    OP_FETCH = 2'd3
  } op_e;

  // Field widths
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned DATA_W     = 12;
  localparam int unsigned CODE_W     = 6;
  localparam int unsigned POS_W      = 7;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned IN_TDATA_W = 48;

  // Command queue between front and back
  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned CMD_PTR_W = 2;
  localparam int unsigned CMD_CNT_W = 3;

  // Slot numbers with special handling
  localparam logic [SLOT_W-1:0] SLOT_TEXT   = 4'd0;
  localparam logic [SLOT_W-1:0] SLOT_SEQ    = 4'd1;
  localparam logic [SLOT_W-1:0] SLOT_FIRST  = 4'd1;
  localparam logic [SLOT_W-1:0] SLOT_MIN    = 4'd2;
  localparam logic [SLOT_W-1:0] SLOT_ZERO   = 4'd3;
  localparam logic [SLOT_W-1:0] SLOT_DIV10  = 4'd4;
  localparam logic [SLOT_W-1:0] SLOT_MANT_A = 4'd12;
  localparam logic [SLOT_W-1:0] SLOT_MANT_B = 4'd14;
  localparam logic [SLOT_W-1:0] SLOT_LAST   = 4'd15;

  // Data saturation
  localparam logic [DATA_W-1:0] DATA_MAX = 12'hfff;

  // Divide by 10: (x * 52429) >> 19, exact for 16-bit x
  localparam logic [15:0] DIV10_MUL = 16'd52429;
  localparam int unsigned DIV10_SH  = 19;
  // Divide by 100: (x * 167773) >> 24, exact below 199728
  localparam logic [17:0] DIV100_MUL = 18'd167773;
  localparam int unsigned DIV100_SH  = 24;
  // Slot 4 saturates once value / 10 reaches 4096
  localparam logic [VALUE_W-1:0] DIV10_SAT = 32'd40960;

  // Mantissa / exponent ranges
  localparam logic [VALUE_W-1:0] MANT_CLIP = 32'd102300;
  localparam logic [VALUE_W-1:0] MANT_E2   = 32'd10000;
  localparam logic [VALUE_W-1:0] MANT_E1   = 32'd1000;
  localparam logic [VALUE_W-1:0] MANT_E0   = 32'd100;
  localparam logic [1:0] EXP_0 = 2'd0;
  localparam logic [1:0] EXP_1 = 2'd1;
  localparam logic [1:0] EXP_2 = 2'd2;
  localparam logic [1:0] EXP_3 = 2'd3;

  // Character codes
  localparam logic [CODE_W-1:0] CODE_SPACE = 6'd37;
  localparam logic [CODE_W-1:0] CODE_DOT   = 6'd38;
  localparam logic [CODE_W-1:0] CODE_COMMA = 6'd39;
  localparam logic [CODE_W-1:0] CODE_EQ    = 6'd40;
  localparam logic [CODE_W-1:0] CODE_COLON = 6'd41;
  localparam logic [CODE_W-1:0] CODE_BANG  = 6'd42;
  localparam logic [CODE_W-1:0] CODE_MINUS = 6'd43;
  localparam logic [CODE_W-1:0] CODE_PLUS  = 6'd44;
  localparam logic [CODE_W-1:0] CODE_OTHER = 6'd63;

  // Command word queued from front to back
  typedef struct packed {
    op_e                op;
    logic [CHAR_W-1:0]  chr;
    logic [SLOT_W-1:0]  slot;
    logic [VALUE_W-1:0] value;
  } cmd_t;

  // Map a stored character to its 6-bit code
  function automatic logic [CODE_W-1:0] char_code(input logic [CHAR_W-1:0] b);
    logic [6:0] c;
    logic [6:0] u;
    logic [CODE_W-1:0] r;
    c = b[6:0];
    // fold lower case onto upper case
    u = (c >= 7'h61 && c <= 7'h7a) ? c - 7'd32 : c;
    if (u >= 7'h41 && u <= 7'h5a) begin
      r = CODE_W'(u - 7'h40);
    end else if (u >= 7'h30 && u <= 7'h39) begin
      r = CODE_W'(u - 7'd21);
    end else begin
      case (u)
        7'h20:   r = CODE_SPACE;
        7'h2e:   r = CODE_DOT;
        7'h2c:   r = CODE_COMMA;
        7'h3d:   r = CODE_EQ;
        7'h3a:   r = CODE_COLON;
        7'h21:   r = CODE_BANG;
        7'h2d:   r = CODE_MINUS;
        7'h2b:   r = CODE_PLUS;
        default: r = CODE_OTHER;
      endcase
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/tewf_ram.sv
`default_nettype none

module tewf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> src/tewf_fifo.sv
`default_nettype none

module tewf_fifo
  import tewf_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t push_cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output cmd_t      head_o
);

  cmd_t                 mem_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMD_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMD_CNT_W-1:0] count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == CMD_CNT_W'(CMD_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and fill count
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + CMD_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + CMD_PTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CMD_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CMD_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CMD_CNT_W'(CMD_DEPTH))
    else $error("command queue count beyond depth");

endmodule

`default_nettype wire

>>> src/tewf_front.sv
`default_nettype none

module tewf_front
  import tewf_pkg::*;
(
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,
  input  wire logic [1:0]            s_axis_tuser,
  input  wire logic                  full_i,
  output logic                       push_o,
  output cmd_t                       cmd_o
);

  logic accept;
  logic keep;

  // Unpack the word
  always_comb begin
    cmd_o.op    = op_e'(s_axis_tuser);
    cmd_o.chr   = s_axis_tdata[7:0];
    cmd_o.slot  = s_axis_tdata[11:8];
    cmd_o.value = s_axis_tdata[43:12];
  end

  // Non-printable characters and writes to slots 0 and 1 are taken and dropped here
  always_comb begin
    keep = 1'b1;
    if (cmd_o.op == OP_PUSH && (cmd_o.chr < 8'h20 || cmd_o.chr > 8'h7e)) begin
      keep = 1'b0;
    end
    if (cmd_o.op == OP_SET && cmd_o.slot < SLOT_MIN) begin
      keep = 1'b0;
    end
  end

  assign s_axis_tready = !full_i;
  assign accept        = s_axis_tvalid && !full_i;
  assign push_o        = accept && keep;

endmodule

`default_nettype wire

>>> src/tewf_back.sv
`default_nettype none

module tewf_back
  import tewf_pkg::*;
#(
  parameter int unsigned MESSAGE_SLOTS  = 4,
  parameter int unsigned MESSAGE_LENGTH = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cmd_t              cmd_i,
  input  wire logic              empty_i,
  output logic                   pop_o,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic      [WORD_W-1:0] m_axis_tdata
);

  localparam int unsigned MSG_IDX_W   = $clog2(MESSAGE_SLOTS);
  localparam int unsigned STORE_DEPTH = MESSAGE_SLOTS * MESSAGE_LENGTH;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam logic [POS_W-1:0]     POS_LIMIT = POS_W'(MESSAGE_LENGTH - 1);
  localparam logic [MSG_IDX_W-1:0] IDX_LAST  = MSG_IDX_W'(MESSAGE_SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TXT1,
    S_TXT2,
    S_SLOT,
    S_EMIT
  } state_e;

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     wc_q, wc_d, rc_q, rc_d;
  logic [MSG_IDX_W-1:0] wi_q, wi_d, ri_q, ri_d;
  logic [POS_W-1:0]     wpos_q, wpos_d, rpos_q, rpos_d;
  logic                 prev_text_q, prev_text_d;
  logic [SLOT_W-1:0]    rot_q, rot_d;
  logic [DATA_W-1:0]    seq_q, seq_d;
  logic                 out_valid_q, out_valid_d;
  logic [WORD_W-1:0]    out_word_q, out_word_d;

  logic [VALUE_W-1:0]   tv_q [16];
  logic [POS_W-1:0]     len_q [MESSAGE_SLOTS];
  logic [VALUE_W-1:0]   v_q, v_d;
  logic [SLOT_W-1:0]    vslot_q, vslot_d;
  logic [CODE_W-1:0]    hi_q, hi_d;
  logic [WORD_W-1:0]    res_q, res_d;

  logic                 tv_we, len_we;
  logic                 ram_we, ram_re;
  logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
  logic [CHAR_W-1:0]    ram_rdata;
  logic                 can_load;
  logic                 emit;
  logic [WORD_W-1:0]    emit_word;
  logic [CODE_W-1:0]    rd_code;
  logic                 at_end;
  logic [MSG_IDX_W-1:0] wi_next, ri_next;
  logic [DATA_W-1:0]    slot_data;

  // Divider datapath for slot words
  logic [15:0]          x10;
  logic [31:0]          prod10;
  logic [12:0]          q10;
  logic [16:0]          clip100, x100;
  logic [34:0]          prod100;
  logic [10:0]          q100;
  logic [DATA_W-1:0]    mant;

  function automatic logic [ADDR_W-1:0] store_addr(input logic [MSG_IDX_W-1:0] s,
                                                   input logic [POS_W-1:0] p);
    return ADDR_W'(s) * ADDR_W'(MESSAGE_LENGTH) + ADDR_W'(p);
  endfunction

  tewf_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(cmd_i.chr),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign can_load  = !out_valid_q || m_axis_tready;
  assign rd_code   = char_code(ram_rdata);
  assign at_end    = (rpos_q >= len_q[ri_q]);
  assign ram_waddr = store_addr(wi_q, wpos_q);
  assign ram_raddr = store_addr(ri_q, rpos_q);

  // Ring index follows count modulo slots, including the 8-bit count wrap
  assign wi_next = (wc_q == '1 || wi_q == IDX_LAST) ? '0 : wi_q + MSG_IDX_W'(1);
  assign ri_next = (rc_q == '1 || ri_q == IDX_LAST) ? '0 : ri_q + MSG_IDX_W'(1);

  // Slot data: divide by 10 shared by slot 4 and the middle mantissa range
  always_comb begin
    x10     = (vslot_q == SLOT_DIV10) ? v_q[15:0] : v_q[15:0] + 16'd5;
    prod10  = 32'(x10) * 32'(DIV10_MUL);
    q10     = prod10[DIV10_SH +: 13];
    clip100 = (v_q > MANT_CLIP) ? MANT_CLIP[16:0] : v_q[16:0];
    x100    = clip100 + 17'd50;
    prod100 = 35'(x100) * 35'(DIV100_MUL);
    q100    = prod100[DIV100_SH +: 11];
    if (v_q >= MANT_E2) begin
      mant = {EXP_2, q100[9:0]};
    end else if (v_q >= MANT_E1) begin
      mant = {EXP_1, q10[9:0]};
    end else if (v_q >= MANT_E0) begin
      mant = {EXP_0, v_q[9:0]};
    end else begin
      mant = {EXP_3, 10'(v_q[6:0]) * 10'd10};
    end
    case (vslot_q) inside
      SLOT_DIV10:               slot_data = (v_q >= DIV10_SAT) ? DATA_MAX : q10[11:0];
      SLOT_MANT_A, SLOT_MANT_B: slot_data = mant;
      default:                  slot_data = (v_q > 32'(DATA_MAX)) ? DATA_MAX : v_q[11:0];
    endcase
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    wc_d        = wc_q;
    rc_d        = rc_q;
    wi_d        = wi_q;
    ri_d        = ri_q;
    wpos_d      = wpos_q;
    rpos_d      = rpos_q;
    prev_text_d = prev_text_q;
    rot_d       = rot_q;
    seq_d       = seq_q;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    v_d         = v_q;
    vslot_d     = vslot_q;
    hi_d        = hi_q;
    res_d       = res_q;
    pop_o       = 1'b0;
    tv_we       = 1'b0;
    len_we      = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    emit        = 1'b0;
    emit_word   = '0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          unique case (cmd_i.op)
            OP_PUSH: begin
              if (wpos_q < POS_LIMIT) begin
                ram_we = 1'b1;
                wpos_d = wpos_q + POS_W'(1);
              end
            end
            OP_CLOSE: begin
              len_we = 1'b1;
              wpos_d = '0;
              wc_d   = wc_q + CNT_W'(1);
              wi_d   = wi_next;
            end
            OP_SET: begin
              tv_we = 1'b1;
            end
            OP_FETCH: begin
              if (!prev_text_q && rc_q != wc_q) begin
                prev_text_d = 1'b1;
                if (at_end) begin
                  // message done: retire it, zero word
                  rc_d   = rc_q + CNT_W'(1);
                  ri_d   = ri_next;
                  rpos_d = '0;
                  emit   = 1'b1;
                end else begin
                  ram_re  = 1'b1;
                  rpos_d  = rpos_q + POS_W'(1);
                  state_d = S_TXT1;
                end
              end else begin
                prev_text_d = 1'b0;
                vslot_d     = rot_q;
                if (rot_q == SLOT_SEQ) begin
                  v_d = 32'(seq_q);
                end else if (rot_q == SLOT_ZERO) begin
                  v_d = '0;
                end else begin
                  v_d = tv_q[rot_q];
                end
                if (rot_q == SLOT_LAST) begin
                  rot_d = SLOT_FIRST;
                  seq_d = seq_q + DATA_W'(1);
                end else begin
                  rot_d = rot_q + SLOT_W'(1);
                end
                state_d = S_SLOT;
              end
            end
          endcase
        end
      end
      S_TXT1: begin
        hi_d = rd_code;
        if (at_end) begin
          rc_d      = rc_q + CNT_W'(1);
          ri_d      = ri_next;
          rpos_d    = '0;
          emit      = 1'b1;
          emit_word = {SLOT_TEXT, rd_code, CODE_W'(0)};
        end else begin
          ram_re  = 1'b1;
          rpos_d  = rpos_q + POS_W'(1);
          state_d = S_TXT2;
        end
      end
      S_TXT2: begin
        emit      = 1'b1;
        emit_word = {SLOT_TEXT, hi_q, rd_code};
      end
      S_SLOT: begin
        emit      = 1'b1;
        emit_word = {vslot_q, slot_data};
      end
      S_EMIT: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          out_word_d  = res_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Finished word goes to the output register, or waits in res_q
    if (emit) begin
      if (can_load) begin
        out_valid_d = 1'b1;
        out_word_d  = emit_word;
        state_d     = S_IDLE;
      end else begin
        res_d   = emit_word;
        state_d = S_EMIT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wc_q        <= '0;
      rc_q        <= '0;
      wi_q        <= '0;
      ri_q        <= '0;
      wpos_q      <= '0;
      rpos_q      <= '0;
      prev_text_q <= 1'b0;
      rot_q       <= SLOT_FIRST;
      seq_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wc_q        <= wc_d;
      rc_q        <= rc_d;
      wi_q        <= wi_d;
      ri_q        <= ri_d;
      wpos_q      <= wpos_d;
      rpos_q      <= rpos_d;
      prev_text_q <= prev_text_d;
      rot_q       <= rot_d;
      seq_q       <= seq_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Telemetry values reset to zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        tv_q[i] <= '0;
      end
    end else if (tv_we) begin
      tv_q[cmd_i.slot] <= cmd_i.value;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_q[wi_q] <= wpos_q;
    end
    v_q        <= v_d;
    vslot_q    <= vslot_d;
    hi_q       <= hi_d;
    res_q      <= res_d;
    out_word_q <= out_word_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_word_q;

  a_txt_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TXT1) |-> ($past(state_q) == S_IDLE))
    else $error("text read started outside idle");

  a_emit_waits_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> out_valid_q)
    else $error("parked word while output register empty");

  a_txt2_marks_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TXT2) |-> prev_text_q)
    else $error("second text read without text flag");

  a_rot_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rot_q != SLOT_TEXT)
    else $error("rotating slot reached text slot");

  a_wpos_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wpos_q <= POS_LIMIT)
    else $error("write position past message limit");

endmodule

`default_nettype wire

>>> src/telemetry_extension_word_framer_top.sv
// Telemetry word framer. Input words carry an operation in tuser (push text
// character, close message, set telemetry slot, fetch next word); only a fetch
// returns an output word, a 16-bit slot number and data pair. A front end
// unpacks each input word, drops non-printable characters and writes to
// slots 0 and 1, and queues the rest in a four-entry command queue; the back
// end runs the queue against the message ring, the telemetry registers and a
// message memory with one write and one read port. Push, close and set are
// handled in the idle state of the back end; a telemetry word passes value
// select, then scale and saturate; a text word reads its characters from the
// message memory, whose read port is registered, and pairs their codes.
// Input is accepted every cycle while the queue has room, and a finished word
// waits in an output register so that later non-fetch words keep flowing.
// No clearing pass follows reset.
`default_nettype none

module telemetry_extension_word_framer_top
  import tewf_pkg::*;
#(
  parameter int unsigned MESSAGE_SLOTS  = 4,
  parameter int unsigned MESSAGE_LENGTH = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // text_char [7:0], slot [11:8], value [43:12], zero pad [47:44]
  input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,
  // operation [1:0]
  input  wire logic [1:0]            s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // word [15:0]
  output logic      [WORD_W-1:0]     m_axis_tdata
);

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic push;
  logic full;
  logic pop;
  logic empty;

  tewf_front u_front (
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .full_i       (full),
    .push_o       (push),
    .cmd_o        (front_cmd)
  );

  tewf_fifo u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(front_cmd),
    .full_o    (full),
    .pop_i     (pop),
    .empty_o   (empty),
    .head_o    (head_cmd)
  );

  tewf_back #(
    .MESSAGE_SLOTS (MESSAGE_SLOTS),
    .MESSAGE_LENGTH(MESSAGE_LENGTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (head_cmd),
    .empty_i      (empty),
    .pop_o        (pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

endmodule

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;
  import tewf_pkg::*;

  localparam int unsigned MSG_SLOTS    = 4;
  localparam int unsigned MSG_LEN      = 64;
  localparam int unsigned RANDOM_ITEMS = 700;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT  = 300000;

  // One input word as the block sees it
  typedef struct packed {
    op_e                op;
    logic [CHAR_W-1:0]  chr;
    logic [SLOT_W-1:0]  slot;
    logic [VALUE_W-1:0] value;
  } framer_cmd_t;

  logic                  clk_i;
  logic                  rst_ni  = 1'b0;
  logic                  s_valid = 1'b0;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic [1:0]            s_tuser = '0;
  logic                  m_ready = 1'b0;
  logic                  s_axis_tready;
  logic                  m_axis_tvalid;
  logic [WORD_W-1:0]     m_axis_tdata;

  framer_cmd_t       command_queue[$];
  framer_cmd_t       cur_cmd;
  logic [WORD_W-1:0] expected_words[$];
  int unsigned       total_items    = 0;
  int unsigned       accepted_items = 0;
  int unsigned       error_count    = 0;
  int unsigned       cycle_count    = 0;
  logic [1:0]        load_phase     = 2'd0;

  // Shadow state of the framer
  logic [CHAR_W-1:0]  msg_mem [MSG_SLOTS*MSG_LEN];
  logic [POS_W-1:0]   msg_len [MSG_SLOTS];
  logic [CNT_W-1:0]   wr_msg_cnt;
  logic [CNT_W-1:0]   rd_msg_cnt;
  logic [POS_W-1:0]   wr_pos;
  logic [POS_W-1:0]   rd_pos;
  logic               text_sent_last;
  logic [SLOT_W-1:0]  next_slot;
  logic [DATA_W-1:0]  seq_num;
  logic [VALUE_W-1:0] tlm_value [16];

  telemetry_extension_word_framer_top #(
    .MESSAGE_SLOTS (MSG_SLOTS),
    .MESSAGE_LENGTH(MSG_LEN)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tuser (s_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [CODE_W-1:0] code_of_char(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] u;
    u = (c >= 8'h61 && c <= 8'h7a) ? c - 8'd32 : c;
    if (u >= 8'h41 && u <= 8'h5a) return CODE_W'(u - 8'h40);
    if (u >= 8'h30 && u <= 8'h39) return CODE_W'(u - 8'h30 + 8'd27);
    case (u)
      8'h20:   return CODE_SPACE;
      8'h2e:   return CODE_DOT;
      8'h2c:   return CODE_COMMA;
      8'h3d:   return CODE_EQ;
      8'h3a:   return CODE_COLON;
      8'h21:   return CODE_BANG;
      8'h2d:   return CODE_MINUS;
      8'h2b:   return CODE_PLUS;
      default: return CODE_OTHER;
    endcase
  endfunction

  // Next character code of the oldest pending message; retires it at its end
  function automatic logic [CODE_W-1:0] pull_code();
    int unsigned ring_idx;
    logic [CHAR_W-1:0] stored;
    if (rd_msg_cnt == wr_msg_cnt) return '0;
    ring_idx = rd_msg_cnt % MSG_SLOTS;
    if (rd_pos >= msg_len[ring_idx]) begin
      rd_msg_cnt = rd_msg_cnt + 1'b1;
      rd_pos     = '0;
      return '0;
    end
    stored = msg_mem[ring_idx*MSG_LEN + (rd_pos % MSG_LEN)];
    rd_pos = rd_pos + 1'b1;
    return code_of_char(stored);
  endfunction

  // 10-bit mantissa with a 2-bit exponent code on top
  function automatic logic [DATA_W-1:0] mant_exp_code(input logic [VALUE_W-1:0] raw);
    longint unsigned v;
    longint unsigned m;
    logic [1:0] ex;
    v = raw;
    if (v >= 10000) begin
      if (v > 102300) v = 102300;
      m  = (v + 50) / 100;
      ex = EXP_2;
    end else if (v >= 1000) begin
      m  = (v + 5) / 10;
      ex = EXP_1;
    end else if (v >= 100) begin
      m  = v;
      ex = EXP_0;
    end else begin
      m  = v * 10;
      ex = EXP_3;
    end
    return {ex, m[9:0]};
  endfunction

  function automatic logic [DATA_W-1:0] scaled_slot_data(input logic [SLOT_W-1:0] s);
    longint unsigned v;
    v = tlm_value[s];
    case (s)
      SLOT_SEQ:                 v = seq_num;
      SLOT_ZERO:                v = 0;
      SLOT_DIV10:               v = v / 10;
      SLOT_MANT_A, SLOT_MANT_B: v = mant_exp_code(tlm_value[s]);
      default: ;
    endcase
    return (v > DATA_MAX) ? DATA_MAX : v[DATA_W-1:0];
  endfunction

  // Advance the shadow state by one accepted word; fetches yield an output word
  function automatic void apply_command(input framer_cmd_t cmd);
    int unsigned wr_idx;
    logic [CODE_W-1:0] first;
    logic [CODE_W-1:0] second;
    logic [WORD_W-1:0] word;
    wr_idx = wr_msg_cnt % MSG_SLOTS;
    case (cmd.op)
      OP_PUSH: begin
        if (cmd.chr >= 8'd32 && cmd.chr <= 8'd126 && wr_pos < MSG_LEN - 1) begin
          msg_mem[wr_idx*MSG_LEN + wr_pos] = cmd.chr;
          wr_pos = wr_pos + 1'b1;
        end
      end
      OP_CLOSE: begin
        msg_len[wr_idx] = wr_pos;
        wr_pos          = '0;
        wr_msg_cnt      = wr_msg_cnt + 1'b1;
      end
      OP_SET: begin
        if (cmd.slot >= SLOT_MIN) tlm_value[cmd.slot] = cmd.value;
      end
      default: begin
        if (!text_sent_last && rd_msg_cnt != wr_msg_cnt) begin
          first = pull_code();
          word  = '0;
          if (first != '0) begin
            second = pull_code();
            word   = {SLOT_TEXT, first, second};
          end
          text_sent_last = 1'b1;
        end else begin
          word = {next_slot, scaled_slot_data(next_slot)};
          if (next_slot == SLOT_LAST) begin
            next_slot = SLOT_FIRST;
            seq_num   = seq_num + 1'b1;
          end else begin
            next_slot = next_slot + 1'b1;
          end
          text_sent_last = 1'b0;
        end
        expected_words.push_back(word);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic queue_cmd(input op_e op, input logic [CHAR_W-1:0] chr,
                           input logic [SLOT_W-1:0] slot, input logic [VALUE_W-1:0] value);
    framer_cmd_t cmd;
    cmd.op    = op;
    cmd.chr   = chr;
    cmd.slot  = slot;
    cmd.value = value;
    command_queue.push_back(cmd);
    total_items++;
  endtask

  // Mostly valid text, some punctuation, some unknown, some non-printable
  function automatic logic [CHAR_W-1:0] pick_char();
    string punct;
    punct = " .,=:!-+";
    case ($urandom_range(0, 9))
      0, 1, 2: return CHAR_W'(8'h41 + $urandom_range(0, 25));
      3, 4:    return CHAR_W'(8'h61 + $urandom_range(0, 25));
      5:       return CHAR_W'(8'h30 + $urandom_range(0, 9));
      6, 7:    return punct[$urandom_range(0, 7)];
      8:       return CHAR_W'($urandom_range(32, 126));
      default: return $urandom_range(0, 1) ? CHAR_W'($urandom_range(0, 31))
                                            : CHAR_W'($urandom_range(127, 255));
    endcase
  endfunction

  // Values clustered around the scaling and saturation edges
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 99);
      1:       return $urandom_range(100, 999);
      2:       return $urandom_range(1000, 9999);
      3:       return $urandom_range(10000, 110000);
      4:       return $urandom_range(4090, 4100);
      5:       return $urandom_range(40950, 40970);
      6:       return $urandom;
      7:       return $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
      8:       return $urandom_range(102290, 102310);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic queue_message(input int unsigned len, input bit close_it);
    for (int unsigned i = 0; i < len; i++)
      queue_cmd(OP_PUSH, pick_char(), SLOT_W'($urandom), $urandom);
    if (close_it) queue_cmd(OP_CLOSE, CHAR_W'($urandom), SLOT_W'($urandom), $urandom);
  endtask

  task automatic build_stimulus();
    int unsigned pick;
    // directed: every character class, drops, ignored and special slots
    queue_cmd(OP_PUSH, "A", 4'h0, 32'h0);
    queue_cmd(OP_PUSH, "z", 4'hf, 32'hffff_ffff);
    queue_cmd(OP_PUSH, "0", 4'h0, 32'h0);
    queue_cmd(OP_PUSH, "9", 4'h0, 32'h0);
    queue_cmd(OP_PUSH, " ", 4'h0, 32'h0);
    queue_cmd(OP_PUSH, ".", 4'h0, 32'h0);
    queue_cmd(OP_PUSH, ",", 4'h0, 32'h0);
    queue_cmd(OP_PUSH, "=", 4'h0, 32'h0);
    queue_cmd(OP_PUSH, ":", 4'h0, 32'h0);
    queue_cmd(OP_PUSH, "!", 4'h0, 32'h0);
    queue_cmd(OP_PUSH, "-", 4'h0, 32'h0);
    queue_cmd(OP_PUSH, "+", 4'h0, 32'h0);
    queue_cmd(OP_PUSH, "~", 4'h0, 32'h0);
    queue_cmd(OP_PUSH, 8'h1f, 4'h0, 32'h0);
    queue_cmd(OP_PUSH, 8'hff, 4'h0, 32'h0);
    queue_cmd(OP_CLOSE, 8'h00, 4'h0, 32'h0);
    queue_cmd(OP_SET, 8'h00, SLOT_TEXT, 32'd77);
    queue_cmd(OP_SET, 8'h00, SLOT_SEQ, 32'd55);
    queue_cmd(OP_SET, 8'h00, SLOT_ZERO, 32'hffff_ffff);
    queue_cmd(OP_SET, 8'h00, SLOT_DIV10, 32'hffff_ffff);
    queue_cmd(OP_SET, 8'h00, SLOT_MANT_A, 32'd102301);
    queue_cmd(OP_SET, 8'h00, SLOT_MANT_B, 32'd9999);
    repeat (6) queue_cmd(OP_FETCH, 8'hff, 4'hf, 32'hffff_ffff);

    // random: messages, bursts of closes, slot updates, fetches
    while (total_items < RANDOM_ITEMS + 28) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        queue_message(($urandom_range(0, 15) == 0) ? $urandom_range(60, 70)
                                                   : $urandom_range(0, 10),
                      $urandom_range(0, 9) != 0);
      end else if (pick < 32) begin
        // more closes than the ring holds
        repeat ($urandom_range(5, 6)) queue_message($urandom_range(0, 3), 1'b1);
      end else if (pick < 50) begin
        repeat ($urandom_range(1, 3))
          queue_cmd(OP_SET, CHAR_W'($urandom), SLOT_W'($urandom), pick_value());
      end else begin
        repeat ($urandom_range(1, 10))
          queue_cmd(OP_FETCH, CHAR_W'($urandom), SLOT_W'($urandom), $urandom);
      end
    end
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i) begin
    int unsigned idle_pct;
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else begin
      if (s_valid && s_axis_tready) begin
        apply_command(cur_cmd);
        accepted_items++;
        load_phase <= (accepted_items * 3 < total_items)     ? 2'd0 :
                      (accepted_items * 3 < 2 * total_items) ? 2'd1 : 2'd2;
      end
      case (load_phase)
        2'd0:    idle_pct = 8;
        2'd1:    idle_pct = 77;
        default: idle_pct = 0;
      endcase
      if (!s_valid || s_axis_tready) begin
        if (command_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          cur_cmd = command_queue.pop_front();
          s_valid <= 1'b1;
          s_tdata <= {4'h0, cur_cmd.value, cur_cmd.slot, cur_cmd.chr};
          s_tuser <= cur_cmd.op;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic note_failure(input string what, input logic [WORD_W-1:0] exp_word,
                              input logic [WORD_W-1:0] act_word);
    if (error_count < 10)
      $display("%0t: %s: expected %04h got %04h", $realtime, what, exp_word, act_word);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    logic [WORD_W-1:0] exp_word;
    int unsigned stall_pct;
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_ready) begin
        if (expected_words.size() == 0) begin
          note_failure("unexpected word", 'x, m_axis_tdata);
        end else begin
          exp_word = expected_words.pop_front();
          if (m_axis_tdata !== exp_word) note_failure("word mismatch", exp_word, m_axis_tdata);
        end
      end
      case (load_phase)
        2'd0:    stall_pct = 77;
        2'd1:    stall_pct = 8;
        default: stall_pct = 0;
      endcase
      m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------- run control

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    foreach (msg_mem[i]) msg_mem[i] = '0;
    foreach (msg_len[i]) msg_len[i] = '0;
    foreach (tlm_value[i]) tlm_value[i] = '0;
    wr_msg_cnt     = '0;
    rd_msg_cnt     = '0;
    wr_pos         = '0;
    rd_pos         = '0;
    text_sent_last = 1'b0;
    next_slot      = SLOT_FIRST;
    seq_num        = '0;
    build_stimulus();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // all words accepted, then every fetch answered, then a quiet tail
    while (command_queue.size() != 0 || s_valid) @(negedge clk_i);
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (error_count == 0 && expected_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
src/tewf_pkg.sv
src/tewf_ram.sv
src/tewf_fifo.sv
src/tewf_front.sv
src/tewf_back.sv
src/telemetry_extension_word_framer_top.sv
bench/tb.sv
